// ----- rtl/core/sbt_pkg.sv -----
// Shared types and constants of the S-expression byte tokenizer.
// Depends on nothing; every other file of the block uses it.
package sbt_pkg;

    // Default width of the byte position and token offsets.
    localparam int POSITION_BITS_DEF = 32;

    // Width of the offsets carried in a result.
    localparam int OFFSET_BITS = 32;

    // Depth of the result queue; a power of two of at least four.
    localparam int FIFO_DEPTH = 4;

    // Characters that the scanner recognizes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_ESCAPE  = 3'd3,
        MODE_ATOM    = 3'd4,
        MODE_DEAD    = 3'd5
    } t_mode;

    // Token kinds reported on the output.
    typedef enum logic [2:0] {
        KIND_ERROR  = 3'd0,
        KIND_END    = 3'd1,
        KIND_OPEN   = 3'd2,
        KIND_CLOSE  = 3'd3,
        KIND_STRING = 3'd4,
        KIND_ATOM   = 3'd5
    } t_kind;

    // Bracket shapes.
    typedef enum logic [1:0] {
        SHAPE_ROUND  = 2'd0,
        SHAPE_SQUARE = 2'd1,
        SHAPE_CURLY  = 2'd2
    } t_shape;

    // One result item.
    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] tok_start;
        logic [OFFSET_BITS-1:0] tok_end;
        t_shape                 shape;
        logic                   last;
    } t_token;

    // Results caused by one byte: up to two, in order.
    typedef struct packed {
        logic [1:0] count;
        t_token     res0;
        t_token     res1;
    } t_scan_out;

    // Result queue status seen by the top level.
    typedef struct packed {
        logic [$clog2(FIFO_DEPTH+1)-1:0] count;
        logic                            room;
    } t_fifo_status;

endpackage

// ----- rtl/core/sbt_scanner.sv -----
// Scanner of the tokenizer: mode, position and token start registers with the
// per-byte decode and result generation. Depends on sbt_pkg.
module sbt_scanner #(
    parameter int POSITION_BITS = sbt_pkg::POSITION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    output sbt_pkg::t_scan_out  o_scan
);

    localparam int EXT_BITS = (POSITION_BITS > sbt_pkg::OFFSET_BITS) ?
                              POSITION_BITS : sbt_pkg::OFFSET_BITS;

    // Position plus one, held at the maximum.
    function automatic logic [POSITION_BITS-1:0] sat_inc(
        input logic [POSITION_BITS-1:0] v
    );
        return (&v) ? v : v + POSITION_BITS'(1);
    endfunction

    // Low offset bits of a position, zero-extended when positions are narrow.
    function automatic logic [sbt_pkg::OFFSET_BITS-1:0] to_offset(
        input logic [POSITION_BITS-1:0] v
    );
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(v);
        return e[sbt_pkg::OFFSET_BITS-1:0];
    endfunction

    function automatic sbt_pkg::t_token make_tok(
        input sbt_pkg::t_kind           kind,
        input logic [POSITION_BITS-1:0] st,
        input logic [POSITION_BITS-1:0] en,
        input sbt_pkg::t_shape          shape,
        input logic                     last
    );
        sbt_pkg::t_token t;
        t.kind      = kind;
        t.tok_start = to_offset(st);
        t.tok_end   = to_offset(en);
        t.shape     = shape;
        t.last      = last;
        return t;
    endfunction

    sbt_pkg::t_mode           r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_begin, n_begin;
    logic [POSITION_BITS-1:0] pos_inc;

    logic            is_zero, is_nl, is_blank, is_semi, is_quote, is_bslash;
    logic            is_open, is_close, is_delim;
    sbt_pkg::t_shape ch_shape;

    // What a byte does between tokens.
    logic                     bt_emit;
    sbt_pkg::t_token          bt_tok;
    sbt_pkg::t_mode           bt_mode;
    logic                     bt_set_begin;

    assign pos_inc = sat_inc(r_pos);

    // Character classes.
    always_comb begin
        is_zero   = (i_byte == sbt_pkg::CH_NUL);
        is_nl     = (i_byte == sbt_pkg::CH_NL);
        is_blank  = (i_byte == sbt_pkg::CH_SPACE) || (i_byte == sbt_pkg::CH_TAB) ||
                    (i_byte == sbt_pkg::CH_FF) || is_nl;
        is_semi   = (i_byte == sbt_pkg::CH_SEMI);
        is_quote  = (i_byte == sbt_pkg::CH_QUOTE);
        is_bslash = (i_byte == sbt_pkg::CH_BSLASH);
        is_open   = (i_byte == sbt_pkg::CH_LPAREN) || (i_byte == sbt_pkg::CH_LBRACK) ||
                    (i_byte == sbt_pkg::CH_LBRACE);
        is_close  = (i_byte == sbt_pkg::CH_RPAREN) || (i_byte == sbt_pkg::CH_RBRACK) ||
                    (i_byte == sbt_pkg::CH_RBRACE);
        is_delim  = is_zero || is_blank || is_semi || is_quote || is_open || is_close;
        if ((i_byte == sbt_pkg::CH_LBRACK) || (i_byte == sbt_pkg::CH_RBRACK)) begin
            ch_shape = sbt_pkg::SHAPE_SQUARE;
        end else if ((i_byte == sbt_pkg::CH_LBRACE) || (i_byte == sbt_pkg::CH_RBRACE)) begin
            ch_shape = sbt_pkg::SHAPE_CURLY;
        end else begin
            ch_shape = sbt_pkg::SHAPE_ROUND;
        end
    end

    // Handling of a byte that arrives between tokens.
    always_comb begin
        bt_emit      = is_zero || is_open || is_close;
        bt_set_begin = 1'b0;
        if (is_zero) begin
            bt_tok = make_tok(sbt_pkg::KIND_END, r_pos, r_pos, sbt_pkg::SHAPE_ROUND, 1'b1);
        end else if (is_open) begin
            bt_tok = make_tok(sbt_pkg::KIND_OPEN, r_pos, pos_inc, ch_shape, 1'b1);
        end else begin
            bt_tok = make_tok(sbt_pkg::KIND_CLOSE, r_pos, pos_inc, ch_shape, 1'b1);
        end
        priority if (is_zero || is_blank || is_open || is_close) begin
            bt_mode = sbt_pkg::MODE_BETWEEN;
        end else if (is_semi) begin
            bt_mode = sbt_pkg::MODE_COMMENT;
        end else if (is_quote) begin
            bt_mode      = sbt_pkg::MODE_STRING;
            bt_set_begin = 1'b1;
        end else begin
            bt_mode      = sbt_pkg::MODE_ATOM;
            bt_set_begin = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        logic restart;
        restart = 1'b0;
        n_mode  = r_mode;
        n_pos   = pos_inc;
        n_begin = r_begin;
        unique case (r_mode)
            sbt_pkg::MODE_COMMENT: begin
                if (is_zero) begin
                    restart = 1'b1;
                end else if (is_nl) begin
                    n_mode = sbt_pkg::MODE_BETWEEN;
                end
            end
            sbt_pkg::MODE_STRING: begin
                // Ordinary string bytes leave the mode unchanged.
                if (is_zero) begin
                    restart = 1'b1;
                end else if (is_nl) begin
                    n_mode = sbt_pkg::MODE_DEAD;
                end else if (is_quote) begin
                    n_mode = sbt_pkg::MODE_BETWEEN;
                end else if (is_bslash) begin
                    n_mode = sbt_pkg::MODE_ESCAPE;
                end
            end
            sbt_pkg::MODE_ESCAPE: begin
                if (is_zero) begin
                    restart = 1'b1;
                end else begin
                    n_mode = sbt_pkg::MODE_STRING;
                end
            end
            sbt_pkg::MODE_ATOM: begin
                if (is_delim) begin
                    n_mode  = bt_mode;
                    restart = is_zero;
                    if (bt_set_begin) begin
                        n_begin = r_pos;
                    end
                end
            end
            sbt_pkg::MODE_DEAD: begin
                restart = is_zero;
            end
            default: begin
                n_mode  = bt_mode;
                restart = is_zero;
                if (bt_set_begin) begin
                    n_begin = r_pos;
                end
            end
        endcase
        // End of text puts everything back to the reset state.
        if (restart) begin
            n_mode  = sbt_pkg::MODE_BETWEEN;
            n_pos   = '0;
            n_begin = '0;
        end
    end

    // Results of the current byte.
    always_comb begin
        o_scan = '0;
        unique case (r_mode)
            sbt_pkg::MODE_COMMENT: begin
                if (is_zero) begin
                    o_scan.count = 2'd1;
                    o_scan.res0  = bt_tok;
                end
            end
            sbt_pkg::MODE_STRING: begin
                if (is_zero || is_nl) begin
                    o_scan.count = 2'd1;
                    o_scan.res0  = make_tok(sbt_pkg::KIND_ERROR, r_begin, r_pos,
                                            sbt_pkg::SHAPE_ROUND, 1'b1);
                end else if (is_quote) begin
                    o_scan.count = 2'd1;
                    o_scan.res0  = make_tok(sbt_pkg::KIND_STRING, r_begin, pos_inc,
                                            sbt_pkg::SHAPE_ROUND, 1'b1);
                end
            end
            sbt_pkg::MODE_ESCAPE: begin
                if (is_zero) begin
                    o_scan.count = 2'd1;
                    o_scan.res0  = make_tok(sbt_pkg::KIND_ERROR, r_begin, r_pos,
                                            sbt_pkg::SHAPE_ROUND, 1'b1);
                end
            end
            sbt_pkg::MODE_ATOM: begin
                // The delimiter closes the atom and is then scanned itself.
                if (is_delim) begin
                    o_scan.res0 = make_tok(sbt_pkg::KIND_ATOM, r_begin, r_pos,
                                           sbt_pkg::SHAPE_ROUND, !bt_emit);
                    o_scan.res1 = bt_tok;
                    o_scan.count = bt_emit ? 2'd2 : 2'd1;
                end
            end
            sbt_pkg::MODE_DEAD: begin
                o_scan.count = 2'd0;
            end
            default: begin
                if (bt_emit) begin
                    o_scan.count = 2'd1;
                    o_scan.res0  = bt_tok;
                end
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sbt_pkg::MODE_BETWEEN;
            r_pos   <= '0;
            r_begin <= '0;
        end else if (i_valid) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
        end
    end

endmodule

// ----- rtl/core/sbt_out_fifo.sv -----
// Result queue of the tokenizer: takes up to two tokens per cycle and hands
// out one per transfer. Depends on sbt_pkg.
module sbt_out_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push_en,
    input  sbt_pkg::t_scan_out     i_push,
    input  logic                   i_pop,
    output logic                   o_valid,
    output sbt_pkg::t_token        o_tok,
    output sbt_pkg::t_fifo_status  o_status
);

    localparam int DEPTH = sbt_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sbt_pkg::t_token r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       push_cnt;
    logic             pop_ok;

    assign push_cnt = i_push_en ? i_push.count : 2'd0;
    assign pop_ok   = i_pop && (r_count != '0);
    assign n_count  = r_count + CNT_W'(push_cnt) - CNT_W'(pop_ok);

    assign o_valid         = (r_count != '0);
    assign o_tok           = r_mem[r_rd_ptr];
    assign o_status.count  = r_count;
    assign o_status.room   = (r_count <= CNT_W'(DEPTH - 2));

    // Storage: the first token at the write pointer, the second after it.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_push.res1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop_ok);
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/core/sexpr_byte_tokenizer.sv -----
// S-expression byte tokenizer: one text byte per input transfer, one token per output transfer.
// A byte is registered in the input register, scanned from there into the result queue and is
// offered from the queue. Throughput: one byte per cycle while the queue has room for two tokens;
// a byte that yields two tokens takes two output transfers, which the four-entry result queue absorbs.
// Reset (i_rst_n low, synchronous): mode between tokens, position and token start zero, queue
// empty.
module sexpr_byte_tokenizer #(
    parameter int POSITION_BITS = sbt_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [31:0] token_start, [63:32] token_end,
                                          // [65:64] bracket_shape, [71:66] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] token_kind
    output logic        o_m_axis_tlast    // last_of_run
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  advance;
    logic                  pop;
    sbt_pkg::t_scan_out    scan;
    sbt_pkg::t_token       out_tok;
    sbt_pkg::t_fifo_status fifo_st;

    // The held byte moves on when the queue has room for two tokens.
    assign advance         = r_in_valid && fifo_st.room;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    sbt_scanner #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .o_scan  (scan)
    );

    sbt_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (advance),
        .i_push    (scan),
        .i_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .o_tok     (out_tok),
        .o_status  (fifo_st)
    );

    // Output packing.
    assign o_m_axis_tdata = {6'd0, out_tok.shape, out_tok.tok_end, out_tok.tok_start};
    assign o_m_axis_tuser = out_tok.kind;
    assign o_m_axis_tlast = out_tok.last;

    // The queue never holds more tokens than it has entries.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_st.count <= ($clog2(sbt_pkg::FIFO_DEPTH + 1))'(sbt_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A scanned byte yields at most two tokens.
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> (scan.count != 2'd3))
        else $error("scanner produced more than two tokens");

    // A byte that yields two tokens marks only the second as last.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (scan.count == 2'd2)) |-> (!scan.res0.last && scan.res1.last))
        else $error("wrong last flag on a token pair");

    // The queue drains to empty when its only token leaves and nothing arrives.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (fifo_st.count == ($clog2(sbt_pkg::FIFO_DEPTH + 1))'(1)) &&
         !(advance && (scan.count != 2'd0))) |=> !o_m_axis_tvalid)
        else $error("result queue did not drain");

endmodule

// ----- dv/sexpr_token_checker.sv -----
// Checker for the S-expression byte tokenizer: watches both streams, predicts tokens, compares.
// Depends on sbt_pkg for the character codes, modes, kinds, shapes and the token record.
`timescale 1ns / 100ps

module sexpr_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream as seen at the block's input.
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    // Token stream as seen at the block's output.
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [71:0] i_m_axis_tdata,   // [31:0] token_start, [63:32] token_end,
                                          // [65:64] bracket_shape, [71:66] zero
    input  logic [2:0]  i_m_axis_tuser,   // [2:0] token_kind
    input  logic        i_m_axis_tlast,   // last_of_run
    output int          o_fail_count,
    output int          o_pending
);

    // Scanner state of the predictor.
    sbt_pkg::t_mode  scan_mode_q;
    logic [31:0]     next_offset;
    logic [31:0]     token_origin;

    // Tokens caused by the byte being scanned, and tokens still owed by the block.
    sbt_pkg::t_token run_buf [2];
    int              run_len;
    sbt_pkg::t_token pending_tokens [$];

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hffff_ffff) ? v : v + 32'd1;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        case (c)
            sbt_pkg::CH_NUL, sbt_pkg::CH_SPACE, sbt_pkg::CH_TAB, sbt_pkg::CH_FF,
            sbt_pkg::CH_NL, sbt_pkg::CH_SEMI, sbt_pkg::CH_QUOTE,
            sbt_pkg::CH_LPAREN, sbt_pkg::CH_RPAREN, sbt_pkg::CH_LBRACK,
            sbt_pkg::CH_RBRACK, sbt_pkg::CH_LBRACE, sbt_pkg::CH_RBRACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic restart_scan();
        scan_mode_q  = sbt_pkg::MODE_BETWEEN;
        next_offset  = '0;
        token_origin = '0;
    endtask

    task automatic add_token(input sbt_pkg::t_kind k, input logic [31:0] st,
                             input logic [31:0] en, input sbt_pkg::t_shape s);
        sbt_pkg::t_token t;
        t.kind      = k;
        t.tok_start = st;
        t.tok_end   = en;
        t.shape     = s;
        t.last      = 1'b0;
        run_buf[run_len] = t;
        run_len++;
    endtask

    // A byte seen between tokens.
    task automatic scan_between(input logic [7:0] c, input logic [31:0] p);
        case (c)
            sbt_pkg::CH_NUL: begin
                add_token(sbt_pkg::KIND_END, p, p, sbt_pkg::SHAPE_ROUND);
                restart_scan();
            end
            sbt_pkg::CH_SPACE, sbt_pkg::CH_TAB, sbt_pkg::CH_FF, sbt_pkg::CH_NL: ;
            sbt_pkg::CH_SEMI:   scan_mode_q = sbt_pkg::MODE_COMMENT;
            sbt_pkg::CH_QUOTE: begin
                token_origin = p;
                scan_mode_q  = sbt_pkg::MODE_STRING;
            end
            sbt_pkg::CH_LPAREN:
                add_token(sbt_pkg::KIND_OPEN, p, sat_inc(p), sbt_pkg::SHAPE_ROUND);
            sbt_pkg::CH_LBRACK:
                add_token(sbt_pkg::KIND_OPEN, p, sat_inc(p), sbt_pkg::SHAPE_SQUARE);
            sbt_pkg::CH_LBRACE:
                add_token(sbt_pkg::KIND_OPEN, p, sat_inc(p), sbt_pkg::SHAPE_CURLY);
            sbt_pkg::CH_RPAREN:
                add_token(sbt_pkg::KIND_CLOSE, p, sat_inc(p), sbt_pkg::SHAPE_ROUND);
            sbt_pkg::CH_RBRACK:
                add_token(sbt_pkg::KIND_CLOSE, p, sat_inc(p), sbt_pkg::SHAPE_SQUARE);
            sbt_pkg::CH_RBRACE:
                add_token(sbt_pkg::KIND_CLOSE, p, sat_inc(p), sbt_pkg::SHAPE_CURLY);
            default: begin
                token_origin = p;
                scan_mode_q  = sbt_pkg::MODE_ATOM;
            end
        endcase
    endtask

    // Advances the predictor by one accepted byte and queues the tokens it causes.
    task automatic scan_byte(input logic [7:0] c);
        logic [31:0] p;
        p           = next_offset;
        next_offset = sat_inc(p);
        run_len     = 0;
        case (scan_mode_q)
            sbt_pkg::MODE_COMMENT: begin
                if (c == sbt_pkg::CH_NUL) scan_between(c, p);
                else if (c == sbt_pkg::CH_NL) scan_mode_q = sbt_pkg::MODE_BETWEEN;
            end
            sbt_pkg::MODE_STRING: begin
                if (c == sbt_pkg::CH_NUL) begin
                    add_token(sbt_pkg::KIND_ERROR, token_origin, p, sbt_pkg::SHAPE_ROUND);
                    restart_scan();
                end else if (c == sbt_pkg::CH_NL) begin
                    add_token(sbt_pkg::KIND_ERROR, token_origin, p, sbt_pkg::SHAPE_ROUND);
                    scan_mode_q = sbt_pkg::MODE_DEAD;
                end else if (c == sbt_pkg::CH_QUOTE) begin
                    add_token(sbt_pkg::KIND_STRING, token_origin, sat_inc(p),
                              sbt_pkg::SHAPE_ROUND);
                    scan_mode_q = sbt_pkg::MODE_BETWEEN;
                end else if (c == sbt_pkg::CH_BSLASH) begin
                    scan_mode_q = sbt_pkg::MODE_ESCAPE;
                end
            end
            sbt_pkg::MODE_ESCAPE: begin
                // A backslash right before the end of text breaks the string.
                if (c == sbt_pkg::CH_NUL) begin
                    add_token(sbt_pkg::KIND_ERROR, token_origin, p, sbt_pkg::SHAPE_ROUND);
                    restart_scan();
                end else begin
                    scan_mode_q = sbt_pkg::MODE_STRING;
                end
            end
            sbt_pkg::MODE_ATOM: begin
                // The delimiter closes the atom and is then scanned on its own.
                if (is_delim(c)) begin
                    add_token(sbt_pkg::KIND_ATOM, token_origin, p, sbt_pkg::SHAPE_ROUND);
                    scan_mode_q = sbt_pkg::MODE_BETWEEN;
                    scan_between(c, p);
                end
            end
            sbt_pkg::MODE_DEAD: begin
                if (c == sbt_pkg::CH_NUL) restart_scan();
            end
            default: begin
                scan_mode_q = sbt_pkg::MODE_BETWEEN;
                scan_between(c, p);
            end
        endcase
        if (run_len > 0) run_buf[run_len-1].last = 1'b1;
        for (int i = 0; i < run_len; i++) pending_tokens.push_back(run_buf[i]);
    endtask

    // Compares one token transfer with the oldest expected token.
    task automatic check_token();
        sbt_pkg::t_token exp_tok;
        if (pending_tokens.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("mismatch: unexpected token kind=%0d start=%0d end=%0d",
                         i_m_axis_tuser, i_m_axis_tdata[31:0], i_m_axis_tdata[63:32]);
        end else begin
            exp_tok = pending_tokens.pop_front();
            if (i_m_axis_tuser !== exp_tok.kind || i_m_axis_tdata[31:0] !== exp_tok.tok_start ||
                i_m_axis_tdata[63:32] !== exp_tok.tok_end ||
                i_m_axis_tdata[65:64] !== exp_tok.shape || i_m_axis_tlast !== exp_tok.last ||
                i_m_axis_tdata[71:66] !== 6'd0) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("mismatch: expected kind=%0d start=%0d end=%0d shape=%0d last=%0b",
                             exp_tok.kind, exp_tok.tok_start, exp_tok.tok_end, exp_tok.shape,
                             exp_tok.last);
                    $display("          got kind=%0d start=%0d end=%0d shape=%0d last=%0b pad=%h",
                             i_m_axis_tuser, i_m_axis_tdata[31:0], i_m_axis_tdata[63:32],
                             i_m_axis_tdata[65:64], i_m_axis_tlast, i_m_axis_tdata[71:66]);
                end
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        run_len      = 0;
        restart_scan();
    end

    // Byte transfers feed the predictor; token transfers are checked against it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_scan();
            pending_tokens.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) scan_byte(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) check_token();
        end
        o_pending = pending_tokens.size();
    end

endmodule

// ----- dv/sexpr_byte_tokenizer_tb.sv -----
// Testbench top of the S-expression byte tokenizer: clock, reset, text stimulus and verdict.
// Depends on sbt_pkg, the block sexpr_byte_tokenizer and the checker sexpr_token_checker.
`timescale 1ns / 100ps

module sexpr_byte_tokenizer_tb;

    localparam int RANDOM_BYTES = 850;
    localparam int CALM_BYTES   = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          tokens_owed;

    // Random stalls on both sides are allowed while this is set.
    logic        stalls_on;
    int          bytes_sent;
    logic [7:0]  directed_text [30];

    sexpr_byte_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    sexpr_token_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_m_axis_tlast  (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (tokens_owed)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Overall time limit of the run.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic is_delim(input logic [7:0] c);
        case (c)
            sbt_pkg::CH_NUL, sbt_pkg::CH_SPACE, sbt_pkg::CH_TAB, sbt_pkg::CH_FF,
            sbt_pkg::CH_NL, sbt_pkg::CH_SEMI, sbt_pkg::CH_QUOTE,
            sbt_pkg::CH_LPAREN, sbt_pkg::CH_RPAREN, sbt_pkg::CH_LBRACK,
            sbt_pkg::CH_RBRACK, sbt_pkg::CH_LBRACE, sbt_pkg::CH_RBRACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] atom_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (is_delim(c));
        return c;
    endfunction

    // Plain string content: anything but quote, backslash, newline and zero.
    function automatic logic [7:0] string_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == sbt_pkg::CH_QUOTE || c == sbt_pkg::CH_BSLASH || c == sbt_pkg::CH_NL);
        return c;
    endfunction

    // Offers one byte and waits for its transfer; the caller is at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic counted);
        if (stalls_on && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (counted) bytes_sent++;
    endtask

    // Sends string content with escapes; the opening quote is already sent.
    task automatic send_string_body();
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) begin
                send_byte(sbt_pkg::CH_BSLASH, 1'b1);
                send_byte(8'($urandom_range(1, 255)), 1'b1);
            end else begin
                send_byte(string_char(), 1'b1);
            end
        end
    endtask

    // Sends one well-formed token, blank run or comment.
    task automatic send_token();
        case ($urandom_range(0, 5))
            0: case ($urandom_range(0, 2))
                0: send_byte(sbt_pkg::CH_LPAREN, 1'b1);
                1: send_byte(sbt_pkg::CH_LBRACK, 1'b1);
                default: send_byte(sbt_pkg::CH_LBRACE, 1'b1);
            endcase
            1: case ($urandom_range(0, 2))
                0: send_byte(sbt_pkg::CH_RPAREN, 1'b1);
                1: send_byte(sbt_pkg::CH_RBRACK, 1'b1);
                default: send_byte(sbt_pkg::CH_RBRACE, 1'b1);
            endcase
            2: repeat ($urandom_range(1, 6)) send_byte(atom_char(), 1'b1);
            3: begin
                send_byte(sbt_pkg::CH_QUOTE, 1'b1);
                send_string_body();
                send_byte(sbt_pkg::CH_QUOTE, 1'b1);
            end
            4: repeat ($urandom_range(1, 3)) case ($urandom_range(0, 3))
                0: send_byte(sbt_pkg::CH_SPACE, 1'b1);
                1: send_byte(sbt_pkg::CH_TAB, 1'b1);
                2: send_byte(sbt_pkg::CH_FF, 1'b1);
                default: send_byte(sbt_pkg::CH_NL, 1'b1);
            endcase
            default: begin
                send_byte(sbt_pkg::CH_SEMI, 1'b1);
                repeat ($urandom_range(0, 5)) begin
                    logic [7:0] c;
                    do c = 8'($urandom_range(1, 255)); while (c == sbt_pkg::CH_NL);
                    send_byte(c, 1'b1);
                end
                send_byte(sbt_pkg::CH_NL, 1'b1);
            end
        endcase
    endtask

    // Output side: ready with random stall bursts while stalls are allowed.
    initial begin
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            m_tready = 1'b1;
        end
    end

    // Stimulus: directed text first, then random texts, then drain and verdict.
    initial begin
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        stalls_on  = 1'b1;
        bytes_sent = 0;
        directed_text = '{
            sbt_pkg::CH_LPAREN, 8'hff, sbt_pkg::CH_RPAREN, sbt_pkg::CH_LBRACK, 8'h61,
            sbt_pkg::CH_TAB, sbt_pkg::CH_RBRACK, sbt_pkg::CH_LBRACE,
            sbt_pkg::CH_FF, sbt_pkg::CH_RBRACE, sbt_pkg::CH_SEMI, 8'h78, sbt_pkg::CH_NUL,
            sbt_pkg::CH_QUOTE, sbt_pkg::CH_BSLASH, sbt_pkg::CH_NL, sbt_pkg::CH_QUOTE,
            sbt_pkg::CH_SPACE, 8'h01, sbt_pkg::CH_QUOTE, sbt_pkg::CH_NL, 8'h71,
            sbt_pkg::CH_NUL,
            sbt_pkg::CH_QUOTE, sbt_pkg::CH_BSLASH, sbt_pkg::CH_NUL,
            sbt_pkg::CH_QUOTE, sbt_pkg::CH_NUL,
            8'h7a, sbt_pkg::CH_NUL
        };
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Brackets of every shape, atoms closed by brackets, blanks and end of text,
        // comment up to end of text, escaped newline, broken strings and the dead mode.
        foreach (directed_text[i]) send_byte(directed_text[i], 1'b0);

        while (bytes_sent < RANDOM_BYTES) begin
            int pick;
            if (bytes_sent > RANDOM_BYTES - CALM_BYTES) stalls_on = 1'b0;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // Well-formed text.
                repeat ($urandom_range(1, 8)) send_token();
            end else if (pick < 9) begin
                // Text that ends in a broken string.
                repeat ($urandom_range(0, 4)) send_token();
                send_byte(sbt_pkg::CH_QUOTE, 1'b1);
                send_string_body();
                case ($urandom_range(0, 2))
                    0: begin
                        send_byte(sbt_pkg::CH_NL, 1'b1);
                        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(1, 255)), 1'b0);
                    end
                    1: send_byte(sbt_pkg::CH_BSLASH, 1'b1);
                    default: ;
                endcase
            end else begin
                // Raw noise.
                repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(1, 255)), 1'b1);
            end
            send_byte(sbt_pkg::CH_NUL, 1'b1);
        end
        s_tvalid = 1'b0;

        while (tokens_owed != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
